// ===== sv/can_tx_mailbox_queue_core_macros.svh =====
// Assertion macros shared by the transmit mailbox queue RTL.
`ifndef CAN_TX_MAILBOX_QUEUE_CORE_MACROS_SVH
`define CAN_TX_MAILBOX_QUEUE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define CTQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("can_tx_mailbox_queue_core assertion failed");
// Property checked on every clock edge, reset included.
`define CTQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("can_tx_mailbox_queue_core assertion failed");
`else
`define CTQ_ASSERT(label, clk, rst_n, prop)
`define CTQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== sv/cantxq_pkg.sv =====
// Types, constants and helpers of the CAN transmit mailbox queue.
`default_nettype none
package cantxq_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ID      = 3'd1,
    ST_BAD_LEN     = 3'd2,
    ST_NOT_STARTED = 3'd3,
    ST_QUEUE_FULL  = 3'd4
  } status_e;

  typedef enum logic {
    KIND_SEND = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  localparam logic [15:0] MAX_ID  = 16'h07FF;
  localparam logic [3:0]  MAX_LEN = 4'd8;
  localparam int unsigned ID_W    = 11;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ENTRY_W = ID_W + LEN_W + DATA_W;

  // Outcome of one beat as decided by the scheduler.
  typedef struct packed {
    status_e    status;
    logic       dispatch;
    logic       from_ring;
    logic [1:0] mbox;
    logic       push;
    logic       pop;
  } decision_t;

  // Clears every payload byte at or above the frame length.
  function automatic logic [DATA_W-1:0] mask_payload(input logic [DATA_W-1:0] data,
                                                     input logic [LEN_W-1:0]  len);
    logic [DATA_W-1:0] res;
    res = '0;
    for (int b = 0; b < 8; b++) begin
      if (LEN_W'(b) < len) begin
        res[b*8 +: 8] = data[b*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cantxq_sched.sv =====
// Request validation and mailbox/ring scheduling decision for one beat.
`default_nettype none
module cantxq_sched (
  input  wire logic                  kind_i,
  input  wire logic [15:0]           frame_id_i,
  input  wire logic [3:0]            frame_length_i,
  input  wire logic [2:0]            mailbox_empty_i,
  input  wire logic                  started_i,
  input  wire logic                  ring_full_i,
  input  wire logic                  ring_nonempty_i,
  output cantxq_pkg::decision_t      dec_o
);

  logic       mbox_free;
  logic [1:0] mbox_pick;

  // Lowest-numbered empty mailbox wins.
  always_comb begin
    mbox_free = |mailbox_empty_i;
    if (mailbox_empty_i[0]) begin
      mbox_pick = 2'd0;
    end else if (mailbox_empty_i[1]) begin
      mbox_pick = 2'd1;
    end else begin
      mbox_pick = 2'd2;
    end
  end

  always_comb begin
    dec_o.status    = cantxq_pkg::ST_OK;
    dec_o.dispatch  = 1'b0;
    dec_o.from_ring = 1'b0;
    dec_o.mbox      = 2'd0;
    dec_o.push      = 1'b0;
    dec_o.pop       = 1'b0;
    case (cantxq_pkg::kind_e'(kind_i))
      cantxq_pkg::KIND_SEND: begin
        if (frame_id_i > cantxq_pkg::MAX_ID) begin
          dec_o.status = cantxq_pkg::ST_BAD_ID;
        end else if (frame_length_i > cantxq_pkg::MAX_LEN) begin
          dec_o.status = cantxq_pkg::ST_BAD_LEN;
        end else if (!started_i) begin
          dec_o.status = cantxq_pkg::ST_NOT_STARTED;
        end else if (mbox_free) begin
          dec_o.dispatch = 1'b1;
          dec_o.mbox     = mbox_pick;
        end else if (!ring_full_i) begin
          dec_o.push = 1'b1;
        end else begin
          dec_o.status = cantxq_pkg::ST_QUEUE_FULL;
        end
      end
      cantxq_pkg::KIND_DONE: begin
        // The oldest waiting frame moves only when a mailbox is free.
        if (ring_nonempty_i && mbox_free) begin
          dec_o.pop       = 1'b1;
          dec_o.dispatch  = 1'b1;
          dec_o.from_ring = 1'b1;
          dec_o.mbox      = mbox_pick;
        end
      end
      default: begin
        dec_o.status = cantxq_pkg::ST_OK;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/can_tx_mailbox_queue_core.sv =====
// Top level of the CAN transmit scheduler with three mailboxes and a frame ring.
`default_nettype none
`include "can_tx_mailbox_queue_core_macros.svh"
// Usage:
// A beat is presented on kind_i and the frame ports and is taken at a rising
// edge with start high and busy low. busy is always low, so one beat can be
// started in every cycle. kind_i selects a send request or a transmit-complete
// event; mailbox_empty_i gives the mailbox flags seen by that beat.
// Each beat produces exactly one result, shown for one cycle with result_valid_o
// high once the beat has passed stage one and stage two. The result gives the
// status, whether a frame is loaded into a mailbox now and which one, that frame,
// the ring fill level and the completion count after the beat.
// Throughput is one beat per cycle: the first stage registers the beat, the
// scheduler decides and updates the ring pointers, fill level and counter in
// that cycle, and the ring is written or read once at the end of it. The
// second stage holds the result and the registered ring read data.
// The receiver cannot stall; results are never held back.
// The user must write driver_started with driver_started_we_i only while no
// beat is in flight; the block does not enforce it. Reset clears the pipeline
// valids, the pointers, the fill level, the counter and driver_started. The ring
// storage needs no clearing: an entry is read only after it has been written.
module can_tx_mailbox_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 kind_i,
  input  wire logic [15:0]                          frame_id_i,
  input  wire logic [3:0]                           frame_length_i,
  input  wire logic [63:0]                          frame_data_i,
  input  wire logic [2:0]                           mailbox_empty_i,
  input  wire logic                                 driver_started_we_i,
  input  wire logic                                 driver_started_i,
  output logic                                      result_valid_o,
  output logic [2:0]                                status_o,
  output logic                                      dispatched_o,
  output logic [1:0]                                mailbox_index_o,
  output logic [10:0]                               out_id_o,
  output logic [3:0]                                out_length_o,
  output logic [63:0]                               out_data_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]          queue_count_o,
  output logic [31:0]                               transmit_count_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  // Stage one: the accepted beat.
  logic        v1_q;
  logic        kind1_q;
  logic [15:0] id1_q;
  logic [3:0]  len1_q;
  logic [63:0] data1_q;
  logic [2:0]  empty1_q;

  // Scheduler state.
  logic             started_q;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [31:0]      tx_cnt_q, tx_cnt_d;

  // Stage two: the result.
  logic                           v2_q;
  cantxq_pkg::status_e            status2_q;
  logic                           disp2_q;
  logic                           ring2_q;
  logic [1:0]                     mbox2_q;
  logic [10:0]                    id2_q;
  logic [3:0]                     len2_q;
  logic [63:0]                    data2_q;
  logic [CNT_W-1:0]               fill2_q;
  logic [31:0]                    cnt2_q;
  logic [cantxq_pkg::ENTRY_W-1:0] rdata_q;

  // Frame ring: {id, length, payload} per entry.
  logic [cantxq_pkg::ENTRY_W-1:0] ring_mem [QUEUE_DEPTH];

  cantxq_pkg::decision_t dec;
  logic [63:0]           masked;
  logic                  is_done;

  assign busy = 1'b0;

  cantxq_sched u_sched (
    .kind_i          (kind1_q),
    .frame_id_i      (id1_q),
    .frame_length_i  (len1_q),
    .mailbox_empty_i (empty1_q),
    .started_i       (started_q),
    .ring_full_i     (fill_q == DEPTH_C),
    .ring_nonempty_i (fill_q != '0),
    .dec_o           (dec)
  );

  assign masked  = cantxq_pkg::mask_payload(data1_q, len1_q);
  assign is_done = (cantxq_pkg::kind_e'(kind1_q) == cantxq_pkg::KIND_DONE);

  // Pointer, fill and counter updates for the beat in stage one.
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    tx_cnt_d = tx_cnt_q;
    if (v1_q) begin
      if (is_done) begin
        tx_cnt_d = tx_cnt_q + 32'd1;
      end
      if (dec.push) begin
        wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
        fill_d   = fill_q + CNT_W'(1);
      end
      if (dec.pop) begin
        rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
        fill_d   = fill_q - CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      started_q <= 1'b0;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      fill_q    <= '0;
      tx_cnt_q  <= '0;
    end else begin
      v1_q     <= start && !busy;
      v2_q     <= v1_q;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      tx_cnt_q <= tx_cnt_d;
      if (driver_started_we_i) begin
        started_q <= driver_started_i;
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind1_q  <= kind_i;
      id1_q    <= frame_id_i;
      len1_q   <= frame_length_i;
      data1_q  <= frame_data_i;
      empty1_q <= mailbox_empty_i;
    end
    if (v1_q) begin
      status2_q <= dec.status;
      disp2_q   <= dec.dispatch;
      ring2_q   <= dec.from_ring;
      mbox2_q   <= dec.mbox;
      // A send that dispatches carries its own frame; others carry zero here.
      if (dec.dispatch && !dec.from_ring) begin
        id2_q   <= id1_q[10:0];
        len2_q  <= len1_q;
        data2_q <= masked;
      end else begin
        id2_q   <= '0;
        len2_q  <= '0;
        data2_q <= '0;
      end
      fill2_q <= fill_d;
      cnt2_q  <= tx_cnt_d;
    end
  end

  // Ring storage: one write or one read per beat, read data registered.
  always_ff @(posedge clk_i) begin
    if (v1_q && dec.push) begin
      ring_mem[wr_ptr_q] <= {id1_q[10:0], len1_q, masked};
    end
    if (v1_q && dec.pop) begin
      rdata_q <= ring_mem[rd_ptr_q];
    end
  end

  assign result_valid_o   = v2_q;
  assign status_o         = status2_q;
  assign dispatched_o     = disp2_q;
  assign mailbox_index_o  = mbox2_q;
  assign out_id_o         = ring2_q ? rdata_q[cantxq_pkg::ENTRY_W-1 -: 11] : id2_q;
  assign out_length_o     = ring2_q ? rdata_q[67:64] : len2_q;
  assign out_data_o       = ring2_q ? rdata_q[63:0] : data2_q;
  assign queue_count_o    = fill2_q;
  assign transmit_count_o = cnt2_q;

  // Every accepted beat yields its result strobe once it has passed stage one and stage two.
  `CTQ_ASSERT(a_result_latency, clk_i, rst_ni, (start && !busy) |-> ##2 result_valid_o)
  // Equal pointers mean the ring is either empty or completely full.
  `CTQ_ASSERT_ALWAYS(a_ptr_fill, clk_i,
                     (wr_ptr_q == rd_ptr_q) |-> (fill_q == '0 || fill_q == DEPTH_C))
  // A frame is only loaded into a mailbox on a successful beat.
  `CTQ_ASSERT(a_dispatch_ok, clk_i, rst_ni,
              (result_valid_o && dispatched_o) |-> (status_o == cantxq_pkg::ST_OK))

endmodule
`default_nettype wire

// ===== tb/can_tx_mailbox_queue_core_test.sv =====
// Self-checking testbench for the CAN transmit mailbox scheduler and its frame ring.
module can_tx_mailbox_queue_core_test;

  // The ring is built at its default depth. The flood phase below is sized
  // against this number, so it must push the ring past full.
  localparam int unsigned RING_DEPTH    = 256;
  localparam int unsigned COUNT_W       = $clog2(RING_DEPTH + 1);
  localparam int unsigned PTR_W         = $clog2(RING_DEPTH);
  // Quiet cycles after the last result before driver_started is rewritten.
  // The pipeline is two stages deep, so this pause is ample.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Cycles to keep watching for stray results once all results are in.
  localparam int unsigned DRAIN_CYCLES  = 6;
  // Cycles without any accepted beat, result or register write that count as
  // a hang. The longest legal quiet stretch is the settle pause plus a gap.
  localparam int unsigned STALL_LIMIT   = 2000;

  // Where the mailbox flags of a random beat come from.
  typedef enum int {
    FLAGS_NONE,  // every mailbox busy, so valid sends land in the ring
    FLAGS_ANY,   // fully random
    FLAGS_SOME   // at least one mailbox free, so completions drain the ring
  } flags_mode_e;

  // One planned entry for the driver: either a beat or a register write.
  typedef struct {
    bit                  is_cfg;
    logic                cfg_value;
    bit                  steady;     // no idle burst may come before this beat
    cantxq_pkg::kind_e   kind;
    logic [15:0]         id;
    logic [3:0]          len;
    logic [63:0]         data;
    logic [2:0]          empty;
  } beat_t;

  // What one beat must produce on the result ports.
  typedef struct {
    cantxq_pkg::status_e  status;
    logic                 dispatched;
    logic [1:0]           mbox;
    logic [10:0]          id;
    logic [3:0]           len;
    logic [63:0]          data;
    logic [COUNT_W-1:0]   fill;
    logic [31:0]          sent;
  } tx_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        start               = 1'b0;
  logic        busy;
  logic        kind_i              = 1'b0;
  logic [15:0] frame_id_i          = '0;
  logic [3:0]  frame_length_i      = '0;
  logic [63:0] frame_data_i        = '0;
  logic [2:0]  mailbox_empty_i     = '0;
  logic        driver_started_we_i = 1'b0;
  logic        driver_started_i    = 1'b0;

  logic               result_valid_o;
  logic [2:0]         status_o;
  logic               dispatched_o;
  logic [1:0]         mailbox_index_o;
  logic [10:0]        out_id_o;
  logic [3:0]         out_length_o;
  logic [63:0]        out_data_o;
  logic [COUNT_W-1:0] queue_count_o;
  logic [31:0]        transmit_count_o;

  can_tx_mailbox_queue_core #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .frame_id_i         (frame_id_i),
    .frame_length_i     (frame_length_i),
    .frame_data_i       (frame_data_i),
    .mailbox_empty_i    (mailbox_empty_i),
    .driver_started_we_i(driver_started_we_i),
    .driver_started_i   (driver_started_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .dispatched_o       (dispatched_o),
    .mailbox_index_o    (mailbox_index_o),
    .out_id_o           (out_id_o),
    .out_length_o       (out_length_o),
    .out_data_o         (out_data_o),
    .queue_count_o      (queue_count_o),
    .transmit_count_o   (transmit_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Planned beats and register writes, filled once before reset is released.
  beat_t      beat_plan[$];
  // Results the scheduler owes us, oldest first.
  tx_result_t pending_results[$];
  beat_t      cur_beat;

  // Shadow of the scheduler: the frame ring, its pointers and fill level,
  // the completion counter and the started flag.
  logic [63:0]      ring_data[RING_DEPTH];
  logic [10:0]      ring_id[RING_DEPTH];
  logic [3:0]       ring_len[RING_DEPTH];
  logic [PTR_W-1:0] ring_head = '0;
  logic [PTR_W-1:0] ring_tail = '0;
  int unsigned      ring_fill = 0;
  logic [31:0]      done_count = '0;
  logic             started_shadow = 1'b0;

  // Run statistics for the summary.
  int unsigned fail_count     = 0;
  int unsigned sends_taken    = 0;
  int unsigned dones_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned loads_direct   = 0;
  int unsigned loads_ring     = 0;
  int unsigned full_refusals  = 0;
  int unsigned ring_peak      = 0;
  int unsigned cfg_writes     = 0;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Works out the result of one accepted beat and advances the shadow state.
  task automatic predict_mailbox_outcome(input beat_t b);
    tx_result_t  r;
    logic [63:0] payload;
    int unsigned slot;
    r.status     = cantxq_pkg::ST_OK;
    r.dispatched = 1'b0;
    r.mbox       = '0;
    r.id         = '0;
    r.len        = '0;
    r.data       = '0;
    // Lowest-numbered free mailbox; 3 means all three are occupied.
    slot = 3;
    if (b.empty[2]) slot = 2;
    if (b.empty[1]) slot = 1;
    if (b.empty[0]) slot = 0;
    if (b.kind == cantxq_pkg::KIND_SEND) begin
      sends_taken++;
      // Checks run in a fixed order and the first failing one wins.
      if (b.id > cantxq_pkg::MAX_ID) begin
        r.status = cantxq_pkg::ST_BAD_ID;
      end else if (b.len > cantxq_pkg::MAX_LEN) begin
        r.status = cantxq_pkg::ST_BAD_LEN;
      end else if (!started_shadow) begin
        r.status = cantxq_pkg::ST_NOT_STARTED;
      end else begin
        // Bytes past the frame length never leave the scheduler.
        if (b.len >= 4'd8) begin
          payload = b.data;
        end else begin
          payload = b.data & ((64'd1 << (int'(b.len) * 8)) - 64'd1);
        end
        if (slot < 3) begin
          // A free mailbox takes the frame even if older frames wait in the ring.
          r.dispatched = 1'b1;
          r.mbox       = slot[1:0];
          r.id         = b.id[10:0];
          r.len        = b.len;
          r.data       = payload;
          loads_direct++;
        end else if (ring_fill < RING_DEPTH) begin
          ring_data[ring_tail] = payload;
          ring_id[ring_tail]   = b.id[10:0];
          ring_len[ring_tail]  = b.len;
          ring_tail            = ring_next(ring_tail);
          ring_fill++;
          if (ring_fill > ring_peak) ring_peak = ring_fill;
        end else begin
          r.status = cantxq_pkg::ST_QUEUE_FULL;
          full_refusals++;
        end
      end
    end else begin
      // A completion always counts, and refills a mailbox only when a frame
      // is waiting and a mailbox is free. The register does not gate it.
      dones_taken++;
      done_count = done_count + 1;
      if (ring_fill > 0 && slot < 3) begin
        r.dispatched = 1'b1;
        r.mbox       = slot[1:0];
        r.id         = ring_id[ring_head];
        r.len        = ring_len[ring_head];
        r.data       = ring_data[ring_head];
        ring_head    = ring_next(ring_head);
        ring_fill--;
        loads_ring++;
      end
    end
    r.fill = COUNT_W'(ring_fill);
    r.sent = done_count;
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  function automatic beat_t send_beat(input logic [15:0] id, input logic [3:0] len,
                                      input logic [63:0] data, input logic [2:0] empty);
    beat_t b;
    b.is_cfg    = 1'b0;
    b.cfg_value = 1'b0;
    b.steady    = 1'b0;
    b.kind      = cantxq_pkg::KIND_SEND;
    b.id        = id;
    b.len       = len;
    b.data      = data;
    b.empty     = empty;
    return b;
  endfunction

  // Completions carry random frame fields, which the scheduler must ignore.
  function automatic beat_t done_beat(input logic [2:0] empty);
    beat_t b;
    b      = send_beat(16'($urandom), 4'($urandom), {$urandom, $urandom}, empty);
    b.kind = cantxq_pkg::KIND_DONE;
    return b;
  endfunction

  function automatic beat_t cfg_beat(input logic value);
    beat_t b;
    b           = send_beat('0, '0, '0, '0);
    b.is_cfg    = 1'b1;
    b.cfg_value = value;
    return b;
  endfunction

  // A random beat: mostly well-formed frames, with a share of bad identifiers
  // and lengths mixed in as noise.
  function automatic beat_t rand_beat(input int unsigned send_pct, input int unsigned noise_pct,
                                      input flags_mode_e flags, input bit steady);
    beat_t       b;
    logic [2:0]  empty;
    case (flags)
      FLAGS_NONE: empty = 3'b000;
      FLAGS_SOME: empty = 3'($urandom_range(1, 7));
      default:    empty = 3'($urandom_range(0, 7));
    endcase
    if ($urandom_range(0, 99) < send_pct) begin
      b = send_beat(16'($urandom_range(0, 2047)), 4'($urandom_range(0, 8)),
                    {$urandom, $urandom}, empty);
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       b.id = 16'($urandom_range(2048, 65535));
          1:       b.len = 4'($urandom_range(9, 15));
          default: begin
            b.id  = 16'($urandom);
            b.len = 4'($urandom);
          end
        endcase
      end
    end else begin
      b = done_beat(empty);
    end
    b.steady = steady;
    return b;
  endfunction

  // Driver. A beat stays on the ports until it is taken. Idle bursts fall
  // between beats at random, except in the steady tail. A register write
  // waits until every owed result is in and the pipeline has been quiet
  // for the settle pause, which also gives the run its full-drain pauses.
  int unsigned gap_left = 0;
  int unsigned settle   = 0;

  always @(posedge clk_i) begin : drive_blk
    beat_t cfg_item;
    logic  nxt_start;
    logic  nxt_we;
    if (!rst_ni) begin
      start               <= 1'b0;
      driver_started_we_i <= 1'b0;
      gap_left = 0;
      settle   = 0;
    end else begin
      if (driver_started_we_i) begin
        started_shadow = driver_started_i;
        cfg_writes++;
      end
      if (start && !busy) begin
        predict_mailbox_outcome(cur_beat);
      end
      nxt_start = start && busy;
      nxt_we    = 1'b0;
      if (!nxt_start && beat_plan.size() > 0) begin
        if (beat_plan[0].is_cfg) begin
          if (pending_results.size() == 0) settle++;
          else settle = 0;
          if (settle >= SETTLE_CYCLES) begin
            cfg_item = beat_plan.pop_front();
            nxt_we   = 1'b1;
            driver_started_i <= cfg_item.cfg_value;
            settle = 0;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (!beat_plan[0].steady && $urandom_range(0, 5) == 0) begin
          // This cycle is the first idle one; gap_left more idle ones follow.
          gap_left = $urandom_range(0, 3);
        end else begin
          cur_beat  = beat_plan.pop_front();
          nxt_start = 1'b1;
          kind_i          <= cur_beat.kind;
          frame_id_i      <= cur_beat.id;
          frame_length_i  <= cur_beat.len;
          frame_data_i    <= cur_beat.data;
          mailbox_empty_i <= cur_beat.empty;
        end
      end
      start               <= nxt_start;
      driver_started_we_i <= nxt_we;
    end
  end

  // Monitor. Every result beat is taken in the cycle it is shown and matched
  // against the oldest owed result.
  always @(posedge clk_i) begin : watch_blk
    tx_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no result owed");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("dispatched", want.dispatched, dispatched_o);
        check_field("mailbox_index", want.mbox, mailbox_index_o);
        check_field("out_id", want.id, out_id_o);
        check_field("out_length", want.len, out_length_o);
        check_field("out_data", want.data, out_data_o);
        check_field("queue_count", want.fill, queue_count_o);
        check_field("transmit_count", want.sent, transmit_count_o);
      end
    end
  end

  // Hang detector: any accepted beat, result or register write resets it.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o === 1'b1 || driver_started_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("can_tx_mailbox_queue_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    // Directed part. The driver starts out stopped, so first the refusal
    // order is checked: a bad identifier beats a bad length, and both beat
    // the not-started refusal.
    beat_plan.push_back(send_beat(16'h0123, 4'd4, 64'h0123_4567_89AB_CDEF, 3'b111));
    beat_plan.push_back(send_beat(16'hFFFF, 4'd15, '1, 3'b111));
    beat_plan.push_back(send_beat(16'h0800, 4'd9, '1, 3'b000));
    beat_plan.push_back(send_beat(16'h07FF, 4'd9, '1, 3'b001));
    // A completion on an empty ring only moves the counter, started or not.
    beat_plan.push_back(done_beat(3'b111));
    beat_plan.push_back(cfg_beat(1'b1));
    // Each mailbox in turn, smallest and largest identifier and length, and
    // payload bytes above the length cleared.
    beat_plan.push_back(send_beat(16'h0000, 4'd0, '1, 3'b001));
    beat_plan.push_back(send_beat(16'h07FF, 4'd8, '1, 3'b110));
    beat_plan.push_back(send_beat(16'h0555, 4'd3, 64'hA5A5_A5A5_A5A5_A5A5, 3'b100));
    // All mailboxes busy: two frames go to the ring.
    beat_plan.push_back(send_beat(16'h02AA, 4'd5, 64'hFEDC_BA98_7654_3210, 3'b000));
    beat_plan.push_back(send_beat(16'h07FF, 4'd8, '1, 3'b000));
    beat_plan.push_back(send_beat(16'h0800, 4'd2, '1, 3'b000));
    beat_plan.push_back(send_beat(16'h0001, 4'd15, '1, 3'b000));
    // Completion with frames waiting but no free mailbox leaves the ring alone.
    beat_plan.push_back(done_beat(3'b000));
    // A send with frames waiting still goes straight to a free mailbox.
    beat_plan.push_back(send_beat(16'h0321, 4'd7, '1, 3'b010));
    beat_plan.push_back(done_beat(3'b100));
    beat_plan.push_back(done_beat(3'b111));
    beat_plan.push_back(done_beat(3'b111));
    beat_plan.push_back(send_beat(16'h0010, 4'd1, 64'h0000_0000_0000_01FF, 3'b011));

    // Random part, in phases that take the ring from light use through full
    // and part of the way back, so the write pointer wraps.
    repeat (15) beat_plan.push_back(rand_beat(60, 12, FLAGS_ANY, 1'b0));
    // Stopped again: valid sends are refused while completions still drain.
    beat_plan.push_back(cfg_beat(1'b0));
    repeat (8) beat_plan.push_back(rand_beat(60, 12, FLAGS_ANY, 1'b0));
    // Flood with every mailbox busy until the ring refuses frames.
    beat_plan.push_back(cfg_beat(1'b1));
    repeat (270) beat_plan.push_back(rand_beat(100, 0, FLAGS_NONE, 1'b0));
    // Drain with mostly completions and at least one free mailbox.
    repeat (120) beat_plan.push_back(rand_beat(15, 10, FLAGS_SOME, 1'b0));
    // Back-to-back tail with no idle cycles at all.
    repeat (20) beat_plan.push_back(rand_beat(55, 12, FLAGS_ANY, 1'b1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beat_plan.size() != 0 || start || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results were never delivered", pending_results.size());
      fail_count++;
    end

    $display("Covered %0d sends and %0d completions, %0d results checked, %0d register writes.",
             sends_taken, dones_taken, results_seen, cfg_writes);
    $display("Mailbox loads: %0d direct, %0d from ring; %0d refused on full ring, peak fill %0d.",
             loads_direct, loads_ring, full_refusals, ring_peak);
    if (fail_count == 0) begin
      $display("can_tx_mailbox_queue_core regression: pass");
    end else begin
      $display("can_tx_mailbox_queue_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== can_tx_mailbox_queue_core.f =====
+incdir+sv
sv/cantxq_pkg.sv
sv/cantxq_sched.sv
sv/can_tx_mailbox_queue_core.sv
tb/can_tx_mailbox_queue_core_test.sv
